FILE: rtl/core/plt_pkg.sv
// Shared types and constants for the positional list table.
// Depends on nothing; every file of the block refers here by scoped names.
`default_nettype none

package plt_pkg;

  // Default number of list cells
  localparam int unsigned DEPTH_DFLT = 64;

  // Request codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOCATE = 2'd2,
    ACT_READ   = 2'd3
  } plt_act_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } plt_status_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } plt_cell_op_t;

  // Request beat
  typedef struct packed {
    plt_act_t           action;
    logic [6:0]         position;
    logic signed [31:0] value;
  } plt_in_t;

  // Result beat
  typedef struct packed {
    plt_status_t        status;
    logic               found;
    logic [6:0]         found_position;
    logic signed [31:0] read_value;
    logic [6:0]         count;
    logic               is_empty;
  } plt_out_t;

  // Command broadcast from the controller to the row of cells
  typedef struct packed {
    plt_cell_op_t       op;
    logic [6:0]         position;
    logic signed [31:0] value;
  } plt_cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/positional_list_table.sv
// Insert, delete and any rejected request give their result in the cycle after
// acceptance, and busy stays low, so such requests may follow in every cycle.
// Locate and a valid read rotate the whole ring of DEPTH cells past the head cell:
// busy is high during the scan; the result comes in the cycle after the last step.
// Reset (rst_n low, synchronous) empties the list; cell contents are left as they are.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`default_nettype none

module positional_list_table #(
  parameter int unsigned DEPTH = plt_pkg::DEPTH_DFLT
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  plt_pkg::plt_in_t  in_data,
  output logic              busy,
  output logic              out_valid,
  output plt_pkg::plt_out_t out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > 7) ? CW : 7) + 1;

  plt_pkg::plt_cell_cmd_t cmd;
  logic signed [31:0]     ent [DEPTH];

  // Sequencer and result register
  plt_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .head_i    (ent[0]),
    .busy      (busy),
    .cmd_o     (cmd),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Ring of cells; each sees both neighbors
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    plt_cell #(
      .Idx  (k),
      .CmpW (PW)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .left_i  (ent[(k + DEPTH - 1) % DEPTH]),
      .right_i (ent[(k + 1) % DEPTH]),
      .entry_o (ent[k])
    );
  end

endmodule

`default_nettype wire

FILE: rtl/core/plt_cell.sv
// One list cell: holds a single entry and moves it to or from its neighbors.
// Depends on plt_pkg for the cell command struct.
`default_nettype none

module plt_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CmpW = 8
) (
  input  wire                     clk,
  input  plt_pkg::plt_cell_cmd_t  cmd,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  output logic signed [31:0]      entry_o
);

  // 1-based position of this cell
  localparam logic [CmpW-1:0] SelfPos = CmpW'(Idx + 1);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;
  logic [CmpW-1:0]    pos_w;

  assign pos_w = CmpW'(cmd.position);

  // Pick the next entry: load, take from a neighbor, or hold
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      plt_pkg::CELL_INS: begin
        if (SelfPos == pos_w) begin
          entry_nxt = cmd.value;
        end else if (SelfPos > pos_w) begin
          entry_nxt = left_i;
        end
      end
      plt_pkg::CELL_DEL: begin
        if (SelfPos >= pos_w) begin
          entry_nxt = right_i;
        end
      end
      plt_pkg::CELL_ROT: begin
        entry_nxt = right_i;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

`default_nettype wire

FILE: rtl/core/plt_ctrl.sv
// Request decoder, entry count, scan sequencer and result register.
// Depends on plt_pkg; drives the command that all cells share.
`default_nettype none

module plt_ctrl #(
  parameter int unsigned DEPTH = plt_pkg::DEPTH_DFLT
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  plt_pkg::plt_in_t        in_data,
  input  wire logic signed [31:0] head_i,
  output logic                    busy,
  output plt_pkg::plt_cell_cmd_t  cmd_o,
  output logic                    out_valid,
  output plt_pkg::plt_out_t       out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned PW = ((CW > 7) ? CW : 7) + 1;
  localparam logic [SW-1:0] LastStep = SW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_SCAN = 2'b10
  } fsm_t;

  fsm_t                 state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  plt_pkg::plt_out_t    out_r, out_nxt;
  logic                 locate_r, locate_nxt;
  logic [6:0]           pos_r, pos_nxt;
  logic signed [31:0]   key_r, key_nxt;
  logic                 found_r, found_nxt;
  logic [6:0]           fpos_r, fpos_nxt;
  logic signed [31:0]   rval_r, rval_nxt;

  logic                 accept;
  logic [PW-1:0]        pos_w, cnt_w, step_pos_w, pos_lat_w;
  logic                 ins_pos_ok, pos_ok, full;
  logic [SW+6:0]        fpos_wide;
  logic [CW+6:0]        cnt_wide;

  assign accept     = start && (state_r == FSM_IDLE);
  assign pos_w      = PW'(in_data.position);
  assign cnt_w      = PW'(count_r);
  assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
  assign full       = (count_r == FullCnt);
  assign step_pos_w = PW'(step_r) + PW'(1);
  assign pos_lat_w  = PW'(pos_r);
  assign fpos_wide  = {7'b0, step_r} + (SW + 7)'(1);
  assign cnt_wide   = {7'b0, count_nxt};

  // Decode requests, step the scan and assemble the result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    locate_nxt    = locate_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    fpos_nxt      = fpos_r;
    rval_nxt      = rval_r;
    cmd_o.op       = plt_pkg::CELL_HOLD;
    cmd_o.position = in_data.position;
    cmd_o.value    = in_data.value;

    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          out_nxt        = '0;
          out_nxt.status = plt_pkg::ST_OK;
          step_nxt       = '0;
          locate_nxt     = (in_data.action == plt_pkg::ACT_LOCATE);
          pos_nxt        = in_data.position;
          key_nxt        = in_data.value;
          found_nxt      = 1'b0;
          fpos_nxt       = '0;
          rval_nxt       = '0;
          case (in_data.action)
            plt_pkg::ACT_INSERT: begin
              out_valid_nxt = 1'b1;
              if (!ins_pos_ok) begin
                out_nxt.status = plt_pkg::ST_RANGE;
              end else if (full) begin
                out_nxt.status = plt_pkg::ST_FULL;
              end else begin
                cmd_o.op  = plt_pkg::CELL_INS;
                count_nxt = count_r + CW'(1);
              end
            end
            plt_pkg::ACT_DELETE: begin
              out_valid_nxt = 1'b1;
              if (!pos_ok) begin
                out_nxt.status = plt_pkg::ST_RANGE;
              end else begin
                cmd_o.op  = plt_pkg::CELL_DEL;
                count_nxt = count_r - CW'(1);
              end
            end
            plt_pkg::ACT_LOCATE: begin
              state_nxt = FSM_SCAN;
            end
            plt_pkg::ACT_READ: begin
              if (!pos_ok) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = plt_pkg::ST_RANGE;
              end else begin
                state_nxt = FSM_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        // Rotate the ring; the head cell holds the entry at step_r
        cmd_o.op = plt_pkg::CELL_ROT;
        if (locate_r) begin
          if (!found_r && (CW'(step_r) < count_r) && (head_i == key_r)) begin
            found_nxt = 1'b1;
            fpos_nxt  = fpos_wide[6:0];
          end
        end else if (step_pos_w == pos_lat_w) begin
          rval_nxt = head_i;
        end
        step_nxt = step_r + SW'(1);
        if (step_r == LastStep) begin
          state_nxt              = FSM_IDLE;
          step_nxt               = '0;
          out_valid_nxt          = 1'b1;
          out_nxt                = '0;
          out_nxt.status         = plt_pkg::ST_OK;
          out_nxt.found          = found_nxt;
          out_nxt.found_position = fpos_nxt;
          out_nxt.read_value     = rval_nxt;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase

    if (out_valid_nxt) begin
      out_nxt.count    = cnt_wide[6:0];
      out_nxt.is_empty = (count_nxt == '0);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan accumulators
  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    locate_r <= locate_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    found_r  <= found_nxt;
    fpos_r   <= fpos_nxt;
    rval_r   <= rval_nxt;
  end

  assign busy      = (state_r == FSM_SCAN);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt)
    else $error("entry count above depth");

  // No result while a scan is still running
  a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_SCAN) && (step_r != LastStep) |=> !out_valid_r)
    else $error("result during scan");

  // The last scan step gives a result and frees the block
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_SCAN) && (step_r == LastStep) |=> out_valid_r && !busy)
    else $error("scan end without result");

  // Count does not move during a scan
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_SCAN) |=> $stable(count_r))
    else $error("count changed during scan");

  // Empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.is_empty == (count_r == '0)))
    else $error("empty flag mismatch");

endmodule

`default_nettype wire
